### rtl/bxt_pkg.sv
// shared constants for the binary xor trie engine
// request kinds, status codes and default sizes; no dependencies
`timescale 1ns / 1ps

package bxt_pkg;

    localparam int KEY_BITS_MAX_DEF = 16;
    localparam int MAX_ITEMS_DEF    = 1024;

    localparam int KEY_W    = 16;
    localparam int LIMIT_W  = 17;
    localparam int ACTION_W = 3;
    localparam int ANSWER_W = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_MAX    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_MIN    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_COUNT  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

endpackage

### rtl/binary_xor_trie_engine.sv
// top level of the binary xor trie engine: request sequencer and result register
// depends on bxt_pkg and bxt_node_ram
`timescale 1ns / 1ps

// Keeps a multiset of keys in a binary trie held in one node memory
// (zero child, one child, pass count per node), walked msb first.
// Requests enter on s_axis: tuser is the action, tdata the key and limit.
// Each request yields one result on m_axis: tdata the answer, tuser the status.
// cfg_valid/cfg_ready writes key_bits; write it only while the block is idle.
// Steps of a request, with kb the effective key_bits:
//   max, min, count: a root read, then a child read and an evaluation per level
//   for up to kb levels; an empty set or large limit answers after the root read
//   insert, remove: a checking walk then an updating walk
//   each level waits on a dependent child read of the node memory
// One request at a time; s_axis_tready is high only while no request is in work.
// The result register lets a new request enter while a result waits; a
// finished request holds until that register is free.
// After reset the node memory is swept to zero, one node a cycle, over all
// MAX_ITEMS*KEY_BITS_MAX+1 nodes (16385 by default); no request is taken then.
module binary_xor_trie_engine
    import bxt_pkg::*;
#(
    parameter int KEY_BITS_MAX = KEY_BITS_MAX_DEF,
    parameter int MAX_ITEMS    = MAX_ITEMS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // key_value [15:0], xor_limit [32:16], zero fill
    input  logic [2:0]  s_axis_tuser,  // action [2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // answer [15:0]
    output logic [1:0]  m_axis_tuser,  // status [1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data       // key_bits
);

    localparam int POOL  = MAX_ITEMS * KEY_BITS_MAX + 1;
    localparam int NW    = $clog2(POOL);
    localparam int NFW   = NW + 1;
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int DW    = 2 * NW + CW;
    localparam int KW    = KEY_BITS_MAX;
    localparam int LW    = (KEY_BITS_MAX > 1) ? $clog2(KEY_BITS_MAX) : 1;
    localparam int KBW   = $clog2(KEY_BITS_MAX + 1);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ROOT  = 4'd2;
    localparam logic [3:0] S_ROOTW = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_EV    = 4'd5;
    localparam logic [3:0] S_LEAF  = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0]          state_reg, state_next;
    logic [NW-1:0]       clr_addr_reg, clr_addr_next;
    logic [NFW-1:0]      next_free_reg, next_free_next;
    logic [CFG_W-1:0]    kb_cfg_reg;
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [KW-1:0]       key_reg, key_next;
    logic [LIMIT_W-1:0]  lim_reg, lim_next;
    logic [LW-1:0]       lvl_reg, lvl_next;
    logic                pass2_reg, pass2_next;
    logic [NW-1:0]       cur_addr_reg, cur_addr_next;
    logic [NW-1:0]       cur_zc_reg, cur_zc_next;
    logic [NW-1:0]       cur_oc_reg, cur_oc_next;
    logic [CW-1:0]       cur_cnt_reg, cur_cnt_next;
    logic [KW-1:0]       ans_reg, ans_next;
    logic [CW-1:0]       sum_reg, sum_next;
    logic [ANSWER_W-1:0] res_ans_reg, res_ans_next;
    logic [STATUS_W-1:0] res_st_reg, res_st_next;
    logic                out_valid_reg, out_valid_next;
    logic [ANSWER_W-1:0] out_ans_reg, out_ans_next;
    logic [STATUS_W-1:0] out_st_reg, out_st_next;

    logic [NW-1:0] rd_a_addr, rd_b_addr, wr_addr;
    logic [DW-1:0] rd_a_data, rd_b_data, wr_data;
    logic          wr_en;

    logic [KBW-1:0] kb_eff;
    logic [NW-1:0]  z_zc, z_oc, o_zc, o_oc;
    logic [CW-1:0]  z_cnt, o_cnt;
    logic [NW-1:0]  b_ptr, b_zc, b_oc, n_ptr, n_zc, n_oc;
    logic [CW-1:0]  b_cnt, n_cnt;
    logic           kbit, lbit, want, b_occ, n_occ;
    logic [LIMIT_W-1:0] lim_shift;
    logic [NFW-1:0] need;
    logic [NW-1:0]  new_ptr;

    bxt_node_ram #(
        .DEPTH (POOL),
        .AW    (NW),
        .DW    (DW)
    ) u_ram (
        .clk       (clk),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    always_comb
    begin
        kb_eff = KBW'(kb_cfg_reg);
        if (kb_cfg_reg == '0)
        begin
            kb_eff = KBW'(1);
        end
        else if (32'(kb_cfg_reg) > KEY_BITS_MAX)
        begin
            kb_eff = KBW'(KEY_BITS_MAX);
        end
    end

    // child words from the two read ports: a holds the zero child, b the one child
    assign {z_zc, z_oc, z_cnt} = rd_a_data;
    assign {o_zc, o_oc, o_cnt} = rd_b_data;

    assign kbit      = key_reg[lvl_reg];
    assign lim_shift = lim_reg >> lvl_reg;
    assign lbit      = lim_shift[0];
    assign want      = (act_reg == ACT_MAX);

    // b side follows the key bit, n side the other branch
    assign b_ptr = kbit ? cur_oc_reg : cur_zc_reg;
    assign b_zc  = kbit ? o_zc : z_zc;
    assign b_oc  = kbit ? o_oc : z_oc;
    assign b_cnt = kbit ? o_cnt : z_cnt;
    assign n_ptr = kbit ? cur_zc_reg : cur_oc_reg;
    assign n_zc  = kbit ? z_zc : o_zc;
    assign n_oc  = kbit ? z_oc : o_oc;
    assign n_cnt = kbit ? z_cnt : o_cnt;
    assign b_occ = (b_ptr != '0) && (b_cnt != '0);
    assign n_occ = (n_ptr != '0) && (n_cnt != '0);
    assign new_ptr = next_free_reg[NW-1:0];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_ans_reg;
    assign m_axis_tuser  = out_st_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        next_free_next = next_free_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        lim_next       = lim_reg;
        lvl_next       = lvl_reg;
        pass2_next     = pass2_reg;
        cur_addr_next  = cur_addr_reg;
        cur_zc_next    = cur_zc_reg;
        cur_oc_next    = cur_oc_reg;
        cur_cnt_next   = cur_cnt_reg;
        ans_next       = ans_reg;
        sum_next       = sum_reg;
        res_ans_next   = res_ans_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        out_ans_next   = out_ans_reg;
        out_st_next    = out_st_reg;
        rd_a_addr      = cur_zc_reg;
        rd_b_addr      = cur_oc_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_addr_reg;
        wr_data        = {cur_zc_reg, cur_oc_reg, cur_cnt_reg};
        need           = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
                clr_addr_next = clr_addr_reg + NW'(1);
                if (32'(clr_addr_reg) == POOL - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next   = s_axis_tuser;
                    key_next   = KW'(s_axis_tdata[15:0]);
                    lim_next   = s_axis_tdata[32:16];
                    pass2_next = 1'b0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                rd_a_addr     = '0;
                cur_addr_next = '0;
                ans_next      = '0;
                sum_next      = '0;
                state_next    = S_ROOTW;
            end
            S_ROOTW:
            begin
                cur_zc_next  = z_zc;
                cur_oc_next  = z_oc;
                cur_cnt_next = z_cnt;
                lvl_next     = LW'(kb_eff - KBW'(1));
                res_ans_next = '0;
                res_st_next  = ST_OK;
                state_next   = S_RD;
                priority if (act_reg != ACT_INSERT && act_reg != ACT_REMOVE &&
                             act_reg != ACT_MAX && act_reg != ACT_MIN &&
                             act_reg != ACT_COUNT)
                begin
                    state_next = S_DONE;
                end
                else if (act_reg == ACT_INSERT && 32'(z_cnt) >= MAX_ITEMS)
                begin
                    res_st_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else if (act_reg != ACT_INSERT && act_reg != ACT_REMOVE && z_cnt == '0)
                begin
                    res_st_next = ST_EMPTY;
                    state_next  = S_DONE;
                end
                else if (act_reg == ACT_COUNT && (lim_reg >> kb_eff) != '0)
                begin
                    res_ans_next = ANSWER_W'(z_cnt);
                    state_next   = S_DONE;
                end
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                state_next = S_RD;
                lvl_next   = lvl_reg - LW'(1);
                unique case (act_reg)
                    ACT_INSERT:
                    begin
                        if (!pass2_reg)
                        begin
                            if (b_ptr == '0 || lvl_reg == '0)
                            begin
                                need = (b_ptr == '0) ? NFW'(lvl_reg) + NFW'(1) : '0;
                                if (32'(next_free_reg) + 32'(need) > POOL)
                                begin
                                    res_st_next = ST_FULL;
                                    state_next  = S_DONE;
                                end
                                else
                                begin
                                    pass2_next = 1'b1;
                                    state_next = S_ROOT;
                                end
                            end
                            else
                            begin
                                cur_addr_next = b_ptr;
                                cur_zc_next   = b_zc;
                                cur_oc_next   = b_oc;
                                cur_cnt_next  = b_cnt;
                            end
                        end
                        else
                        begin
                            wr_en = 1'b1;
                            if (b_ptr == '0)
                            begin
                                // take a fresh node from the pool
                                wr_data = kbit ? {cur_zc_reg, new_ptr, cur_cnt_reg + CW'(1)}
                                               : {new_ptr, cur_oc_reg, cur_cnt_reg + CW'(1)};
                                next_free_next = next_free_reg + NFW'(1);
                                cur_addr_next  = new_ptr;
                                cur_zc_next    = '0;
                                cur_oc_next    = '0;
                                cur_cnt_next   = '0;
                            end
                            else
                            begin
                                wr_data = {cur_zc_reg, cur_oc_reg, cur_cnt_reg + CW'(1)};
                                cur_addr_next = b_ptr;
                                cur_zc_next   = b_zc;
                                cur_oc_next   = b_oc;
                                cur_cnt_next  = b_cnt;
                            end
                            if (lvl_reg == '0)
                            begin
                                state_next = S_LEAF;
                            end
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (!pass2_reg)
                        begin
                            if (b_ptr == '0 || (lvl_reg == '0 && b_cnt == '0))
                            begin
                                res_st_next = ST_ABSENT;
                                state_next  = S_DONE;
                            end
                            else if (lvl_reg == '0)
                            begin
                                pass2_next = 1'b1;
                                state_next = S_ROOT;
                            end
                            else
                            begin
                                cur_addr_next = b_ptr;
                                cur_zc_next   = b_zc;
                                cur_oc_next   = b_oc;
                                cur_cnt_next  = b_cnt;
                            end
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_data = {cur_zc_reg, cur_oc_reg,
                                       (cur_cnt_reg != '0) ? cur_cnt_reg - CW'(1) : cur_cnt_reg};
                            cur_addr_next = b_ptr;
                            cur_zc_next   = b_zc;
                            cur_oc_next   = b_oc;
                            cur_cnt_next  = b_cnt;
                            if (lvl_reg == '0)
                            begin
                                state_next = S_LEAF;
                            end
                        end
                    end
                    ACT_COUNT:
                    begin
                        if (lbit)
                        begin
                            // every key on the matching branch is below the limit
                            if (b_ptr != '0)
                            begin
                                sum_next = sum_reg + b_cnt;
                            end
                            cur_addr_next = n_ptr;
                            cur_zc_next   = n_zc;
                            cur_oc_next   = n_oc;
                            cur_cnt_next  = n_cnt;
                            if (n_ptr == '0 || lvl_reg == '0)
                            begin
                                res_ans_next = ANSWER_W'((b_ptr != '0) ? sum_reg + b_cnt : sum_reg);
                                state_next   = S_DONE;
                            end
                        end
                        else
                        begin
                            cur_addr_next = b_ptr;
                            cur_zc_next   = b_zc;
                            cur_oc_next   = b_oc;
                            cur_cnt_next  = b_cnt;
                            if (b_ptr == '0 || lvl_reg == '0)
                            begin
                                res_ans_next = ANSWER_W'(sum_reg);
                                state_next   = S_DONE;
                            end
                        end
                    end
                    default:
                    begin
                        // max and min: the preferred branch flips the key bit for max
                        if ((want && n_occ) || (!want && b_occ))
                        begin
                            ans_next[lvl_reg] = want;
                            cur_addr_next = want ? n_ptr : b_ptr;
                            cur_zc_next   = want ? n_zc : b_zc;
                            cur_oc_next   = want ? n_oc : b_oc;
                            cur_cnt_next  = want ? n_cnt : b_cnt;
                        end
                        else if ((want && b_occ) || (!want && n_occ))
                        begin
                            ans_next[lvl_reg] = !want;
                            cur_addr_next = want ? b_ptr : n_ptr;
                            cur_zc_next   = want ? b_zc : n_zc;
                            cur_oc_next   = want ? b_oc : n_oc;
                            cur_cnt_next  = want ? b_cnt : n_cnt;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                        if (lvl_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        res_ans_next = ANSWER_W'(ans_next);
                    end
                endcase
            end
            S_LEAF:
            begin
                wr_en = 1'b1;
                if (act_reg == ACT_INSERT)
                begin
                    wr_data = {cur_zc_reg, cur_oc_reg, cur_cnt_reg + CW'(1)};
                end
                else
                begin
                    wr_data = {cur_zc_reg, cur_oc_reg,
                               (cur_cnt_reg != '0) ? cur_cnt_reg - CW'(1) : cur_cnt_reg};
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_ans_next   = res_ans_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_addr_reg  <= '0;
            next_free_reg <= NFW'(1);
            kb_cfg_reg    <= CFG_W'(16);
            pass2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            next_free_reg <= next_free_next;
            pass2_reg     <= pass2_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                kb_cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        key_reg      <= key_next;
        lim_reg      <= lim_next;
        lvl_reg      <= lvl_next;
        cur_addr_reg <= cur_addr_next;
        cur_zc_reg   <= cur_zc_next;
        cur_oc_reg   <= cur_oc_next;
        cur_cnt_reg  <= cur_cnt_next;
        ans_reg      <= ans_next;
        sum_reg      <= sum_next;
        res_ans_reg  <= res_ans_next;
        res_st_reg   <= res_st_next;
        out_ans_reg  <= out_ans_next;
        out_st_reg   <= out_st_next;
    end

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(next_free_reg) <= POOL)
        else $error("node pool pointer ran past the pool");

    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("request taken or result shown during memory clear");

    a_done_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && m_axis_tready) |=> out_valid_reg && state_reg == S_IDLE)
        else $error("finished request did not reach the result register");

    a_alloc_in_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != $past(next_free_reg) && state_reg != S_CLR) |->
            act_reg == ACT_INSERT && $past(pass2_reg))
        else $error("pool node taken outside an insert update walk");

endmodule

### rtl/bxt_node_ram.sv
// node store of the trie: one write port, two registered read ports
// depends on nothing but its parameters
`timescale 1ns / 1ps

module bxt_node_ram #(
    parameter int DEPTH = 16385,
    parameter int AW    = 15,
    parameter int DW    = 41
) (
    input  logic          clk,
    input  logic [AW-1:0] rd_a_addr,
    output logic [DW-1:0] rd_a_data,
    input  logic [AW-1:0] rd_b_addr,
    output logic [DW-1:0] rd_b_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule
